// ----- rtl/core/euler_zxz_pose_matrix_core_defines.svh -----
// Assertion macros shared by the pose matrix core.
`ifndef EULER_ZXZ_POSE_MATRIX_CORE_DEFINES_SVH
`define EULER_ZXZ_POSE_MATRIX_CORE_DEFINES_SVH
// Clocked implication, disabled while reset is low.
`define EZP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Clocked next-cycle implication, disabled while reset is low.
`define EZP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/ezp_pkg.sv -----
// Package: payload types and fixed-point constants of the pose matrix core.
package ezp_pkg;
    typedef struct packed {
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_tilt;
        logic signed [15:0] angle_last;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] out_shift_x;
        logic signed [31:0] out_shift_y;
        logic signed [31:0] out_shift_z;
    } t_out;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sh3243F6A8;
            5'd1:  v = 34'sh1DAC6705;
            5'd2:  v = 34'sh0FADBAFC;
            5'd3:  v = 34'sh07F56EA6;
            5'd4:  v = 34'sh03FEAB76;
            5'd5:  v = 34'sh01FFD55B;
            5'd6:  v = 34'sh00FFFAAA;
            5'd7:  v = 34'sh007FFF55;
            5'd8:  v = 34'sh003FFFEA;
            5'd9:  v = 34'sh001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            5'd20: v = 34'sh000003FF;
            5'd21: v = 34'sh000001FF;
            5'd22: v = 34'sh000000FF;
            5'd23: v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ----- rtl/core/ezp_cordic.sv -----
// Pipelined sine/cosine unit: range reduction, one CORDIC step per stage, Q20 rounding.
module ezp_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [21:0] o_sin,
    output logic signed [21:0] o_cos
);
    import ezp_pkg::*;

    localparam int N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

    logic signed [35:0] w_z0, w_z1, w_z2;
    logic               w_flip;
    logic signed [33:0] r_z [0:N];
    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic               r_flip [0:N];
    logic signed [33:0] w_xf, w_yf;

    // Reduce into [-pi/2, pi/2]; one wrap suffices for a Q4.12 input.
    always_comb begin
        w_z0 = 36'(i_angle) <<< 18;
        w_z1 = w_z0;
        if (w_z0 > Q30_PI) begin
            w_z1 = w_z0 - Q30_TWO_PI;
        end else if (w_z0 < -Q30_PI) begin
            w_z1 = w_z0 + Q30_TWO_PI;
        end
        w_z2 = w_z1;
        w_flip = 1'b0;
        if (w_z1 > Q30_HALF_PI) begin
            w_z2 = w_z1 - Q30_PI;
            w_flip = 1'b1;
        end else if (w_z1 < -Q30_HALF_PI) begin
            w_z2 = w_z1 + Q30_PI;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= w_z2[33:0];
            r_x[0]    <= Q30_GAIN;
            r_y[0]    <= '0;
            r_flip[0] <= w_flip;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[g+1] <= r_flip[g];
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(5'(g));
                end
            end
        end
    end

    always_comb begin
        w_xf = r_flip[N] ? -r_x[N] : r_x[N];
        w_yf = r_flip[N] ? -r_y[N] : r_y[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= 22'((w_xf + 34'sd512) >>> 10);
            o_sin <= 22'((w_yf + 34'sd512) >>> 10);
        end
    end
endmodule

// ----- rtl/core/euler_zxz_pose_matrix_core.sv -----
// Top level of the Euler ZXZ pose matrix core.
// Pose matrix core: takes three Q4.12 Euler angles (a, b, g) and a Q16.16
// translation and returns [R|T] with R = Rz(g)*Rx(b)*Rz(a), entries Q2.14
// rounded half up and saturated to +-1.0; the translation passes through.
// The pipeline accepts one transfer every clock unless the output is
// stalled. Its stages: range reduction, one stage per CORDIC step, Q20
// rounding, two product stages, sum/round stage. A stall on the output
// freezes the whole pipeline; the output register holds its transfer until
// taken, and a new input is taken whenever the output is free or moving.
module euler_zxz_pose_matrix_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ezp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output ezp_pkg::t_out o_data
);
    import ezp_pkg::*;
    `include "euler_zxz_pose_matrix_core_defines.svh"

    localparam int N   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int LAT = N + 5;

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    logic [LAT-1:0]     n_vld;
    logic signed [95:0] r_shift [0:LAT-2];
    logic signed [21:0] w_sa, w_ca, w_sb, w_cb, w_sg, w_cg;

    // Advance everything unless a held output is stalled.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_comb begin
        n_vld = {r_vld[LAT-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    ezp_cordic #(.STEPS(N)) u_cor_a (.i_clk(i_clk), .i_en(w_en),
        .i_angle(i_data.angle_first), .o_sin(w_sa), .o_cos(w_ca));
    ezp_cordic #(.STEPS(N)) u_cor_b (.i_clk(i_clk), .i_en(w_en),
        .i_angle(i_data.angle_tilt), .o_sin(w_sb), .o_cos(w_cb));
    ezp_cordic #(.STEPS(N)) u_cor_g (.i_clk(i_clk), .i_en(w_en),
        .i_angle(i_data.angle_last), .o_sin(w_sg), .o_cos(w_cg));

    // Translation rides alongside the math stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_shift[0] <= {i_data.shift_x, i_data.shift_y, i_data.shift_z};
            for (int k = 1; k < LAT - 1; k++) begin
                r_shift[k] <= r_shift[k-1];
            end
        end
    end

    // Product stage 1: pairs in Q40.
    logic signed [43:0] r_cgca, r_sgsa, r_cgsa, r_sgca, r_sgsb, r_cgsb;
    logic signed [43:0] r_sbsa, r_sbca, r_sgcb, r_cgcb;
    logic signed [21:0] r_sa1, r_ca1, r_cb1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cgca <= 44'(w_cg * w_ca);
            r_sgsa <= 44'(w_sg * w_sa);
            r_cgsa <= 44'(w_cg * w_sa);
            r_sgca <= 44'(w_sg * w_ca);
            r_sgsb <= 44'(w_sg * w_sb);
            r_cgsb <= 44'(w_cg * w_sb);
            r_sbsa <= 44'(w_sb * w_sa);
            r_sbca <= 44'(w_sb * w_ca);
            r_sgcb <= 44'(w_sg * w_cb);
            r_cgcb <= 44'(w_cg * w_cb);
            r_sa1  <= w_sa;
            r_ca1  <= w_ca;
            r_cb1  <= w_cb;
        end
    end

    // Product stage 2: every term in Q60.
    logic signed [65:0] r_t [0:13];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t[0]  <= 66'(r_cgca) <<< 20;
            r_t[1]  <= 66'(r_sgcb * r_sa1);
            r_t[2]  <= 66'(r_cgsa) <<< 20;
            r_t[3]  <= 66'(r_sgcb * r_ca1);
            r_t[4]  <= 66'(r_sgsb) <<< 20;
            r_t[5]  <= 66'(r_sgca) <<< 20;
            r_t[6]  <= 66'(r_cgcb * r_sa1);
            r_t[7]  <= 66'(r_sgsa) <<< 20;
            r_t[8]  <= 66'(r_cgcb * r_ca1);
            r_t[9]  <= 66'(r_cgsb) <<< 20;
            r_t[10] <= 66'(r_sbsa) <<< 20;
            r_t[11] <= 66'(r_sbca) <<< 20;
            r_t[12] <= 66'(r_cb1) <<< 40;
            r_t[13] <= '0;
        end
    end

    function automatic logic signed [15:0] to_q14(input logic signed [65:0] v);
        logic signed [65:0] s;
        s = (v + (66'sd1 <<< 45)) >>> 46;
        if (s > 66'sd16384) begin
            return 16'sd16384;
        end else if (s < -66'sd16384) begin
            return -16'sd16384;
        end
        return s[15:0];
    endfunction

    // Sum, round, saturate into the output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_data.r00 <= to_q14(r_t[0] - r_t[1]);
            o_data.r01 <= to_q14(-r_t[2] - r_t[3]);
            o_data.r02 <= to_q14(r_t[4] + r_t[13]);
            o_data.r10 <= to_q14(r_t[5] + r_t[6]);
            o_data.r11 <= to_q14(r_t[8] - r_t[7]);
            o_data.r12 <= to_q14(-r_t[9]);
            o_data.r20 <= to_q14(r_t[10]);
            o_data.r21 <= to_q14(r_t[11]);
            o_data.r22 <= to_q14(r_t[12]);
            o_data.out_shift_x <= r_shift[LAT-2][95:64];
            o_data.out_shift_y <= r_shift[LAT-2][63:32];
            o_data.out_shift_z <= r_shift[LAT-2][31:0];
        end
    end

    `EZP_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_data), "stalled output transfer changed")
    `EZP_ASSERT_IMP(a_stall_only_when_held, i_clk, i_rst_n, o_stall,
        o_valid && i_stall, "input stalled without a held output")
    `EZP_ASSERT_IMP(a_r22_range, i_clk, i_rst_n, o_valid,
        (o_data.r22 <= 16'sd16384) && (o_data.r22 >= -16'sd16384),
        "rotation entry out of range")
endmodule

// ----- tb/testbench.sv -----
// Testbench for the Euler ZXZ pose matrix core: directed and random poses checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import ezp_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 5;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic out_stall;
    t_in  in_pose;
    logic res_valid;
    logic res_stall;
    t_out res_pose;

    // Matrices still in flight, oldest first.
    t_out pending_poses[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   idling_on = 1;

    euler_zxz_pose_matrix_core #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (out_stall),
        .i_data  (in_pose),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_data  (res_pose)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor shift of a signed value; >>> on a signed longint floors already.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Sine and cosine of a Q4.12 angle in Q20, by rotation-mode CORDIC in Q30.
    task automatic angle_sincos(input logic signed [15:0] ang,
                                output longint s20, output longint c20);
        longint z, x, y, nx, step_atan;
        bit     flip;
        int     n;
        z = longint'(ang) * 262144;
        x = Q30_GAIN;
        y = 0;
        flip = 0;
        n = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
        while (z > Q30_PI) z -= Q30_TWO_PI;
        while (z < -Q30_PI) z += Q30_TWO_PI;
        if (z > Q30_HALF_PI) begin
            z -= Q30_PI;
            flip = 1;
        end else if (z < -Q30_HALF_PI) begin
            z += Q30_PI;
            flip = 1;
        end
        for (int i = 0; i < n; i++) begin
            // Arctangent of 2^-i in Q30: round trip through real is exact enough?
            // No: keep it bit exact from the table values below.
            case (i)
                0:  step_atan = 64'h3243F6A8;
                1:  step_atan = 64'h1DAC6705;
                2:  step_atan = 64'h0FADBAFC;
                3:  step_atan = 64'h07F56EA6;
                4:  step_atan = 64'h03FEAB76;
                5:  step_atan = 64'h01FFD55B;
                6:  step_atan = 64'h00FFFAAA;
                7:  step_atan = 64'h007FFF55;
                8:  step_atan = 64'h003FFFEA;
                9:  step_atan = 64'h001FFFFD;
                default: step_atan = (64'h1 << (30 - i)) - 1;
            endcase
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= step_atan;
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += step_atan;
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c20 = floor_shift(x + 512, 10);
        s20 = floor_shift(y + 512, 10);
    endtask

    // Round a Q60 sum half up to Q14 and clamp to +-1.0.
    function automatic logic signed [15:0] round_entry(longint q60);
        longint v;
        v = floor_shift(q60 + (longint'(1) << 45), 46);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    task automatic predict_pose(input t_in p, output t_out m);
        longint sa, ca, sb, cb, sg, cg, one;
        one = 1048576;
        angle_sincos(p.angle_first, sa, ca);
        angle_sincos(p.angle_tilt, sb, cb);
        angle_sincos(p.angle_last, sg, cg);
        m.r00 = round_entry(cg * ca * one - sg * cb * sa);
        m.r01 = round_entry(-(cg * sa * one) - sg * cb * ca);
        m.r02 = round_entry(sg * sb * one);
        m.r10 = round_entry(sg * ca * one + cg * cb * sa);
        m.r11 = round_entry(-(sg * sa * one) + cg * cb * ca);
        m.r12 = round_entry(-(cg * sb * one));
        m.r20 = round_entry(sb * sa * one);
        m.r21 = round_entry(sb * ca * one);
        m.r22 = round_entry(cb * one * one);
        m.out_shift_x = p.shift_x;
        m.out_shift_y = p.shift_y;
        m.out_shift_z = p.shift_z;
    endtask

    task automatic report_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Check each result transfer against the oldest predicted matrix.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && res_valid && !res_stall) begin
            if (pending_poses.size() == 0) begin
                $error("unexpected result transfer");
                error_count++;
            end else begin
                want = pending_poses.pop_front();
                report_field("r00", want.r00, res_pose.r00);
                report_field("r01", want.r01, res_pose.r01);
                report_field("r02", want.r02, res_pose.r02);
                report_field("r10", want.r10, res_pose.r10);
                report_field("r11", want.r11, res_pose.r11);
                report_field("r12", want.r12, res_pose.r12);
                report_field("r20", want.r20, res_pose.r20);
                report_field("r21", want.r21, res_pose.r21);
                report_field("r22", want.r22, res_pose.r22);
                report_field("out_shift_x", want.out_shift_x, res_pose.out_shift_x);
                report_field("out_shift_y", want.out_shift_y, res_pose.out_shift_y);
                report_field("out_shift_z", want.out_shift_z, res_pose.out_shift_z);
            end
        end
    end

    // Stall the result side in random bursts, none once idling is switched off.
    initial begin
        int burst;
        res_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                res_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((in_valid && !out_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Send one pose: hold valid until the transfer, with an optional gap first.
    task automatic send_pose(input t_in p);
        t_out m;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pose  <= p;
        @(posedge i_clk);
        while (out_stall) @(posedge i_clk);
        predict_pose(p, m);
        pending_poses.push_back(m);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in random_pose();
        t_in p;
        p = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        // Favor the principal range now and then.
        if ($urandom_range(0, 1)) begin
            p.angle_first = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            p.angle_tilt  = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            p.angle_last  = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
        end
        return p;
    endfunction

    // Extremes of the angles (+-8, +-pi, +-pi/2, zero) and of the translation.
    task automatic test_directed();
        logic signed [15:0] angles[10] = '{16'sh8000, 16'sh7FFF, 16'sd12868, -16'sd12868,
            16'sd12867, 16'sd6434, -16'sd6434, 16'sd0, 16'sd1, -16'sd1};
        t_in p;
        for (int i = 0; i < 10; i++) begin
            p.angle_first = angles[i];
            p.angle_tilt  = angles[(i + 3) % 10];
            p.angle_last  = angles[(i + 7) % 10];
            p.shift_x = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
            p.shift_y = (i % 3) ? 32'sd0 : -32'sd1;
            p.shift_z = $urandom;
            send_pose(p);
        end
        // Entries at exactly one: all angles zero, and tilt at pi/2.
        p = '0;
        send_pose(p);
        p.angle_tilt = 16'sd6434;
        send_pose(p);
        drop_valid();
    endtask

    // Hold off the sender until every matrix in flight has arrived.
    task automatic test_drain();
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_pose(random_pose());
        drop_valid();
    endtask

    initial begin
        in_valid <= 1'b0;
        in_pose  <= '0;
        i_rst_n  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain();
        test_random(550);
        test_drain();
        // Last part: back-to-back with no idling on either side.
        idling_on = 0;
        test_random(150);

        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
